// ----- hdl/tcgl_pkg.sv -----
// Package for the text cursor glyph layout block.
// Holds request and operation codes, configuration and result types, and the queue entry.
// No dependencies; used by every module of the block except tcgl_ram.
package tcgl_pkg;

   localparam int GLYPH_COUNT   = 96;
   localparam int GLYPH_ADDR_W  = $clog2(GLYPH_COUNT);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = QUEUE_PTR_W + 1;

   // Request kinds as they arrive on tuser
   localparam logic [2:0] REQ_CHAR    = 3'd0;
   localparam logic [2:0] REQ_RESET   = 3'd1;
   localparam logic [2:0] REQ_OFFSET  = 3'd2;
   localparam logic [2:0] REQ_SAVE    = 3'd3;
   localparam logic [2:0] REQ_RESTORE = 3'd4;
   localparam logic [2:0] REQ_WIDTH   = 3'd5;

   // Configuration register indexes
   localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
   localparam logic [2:0] REG_AREA_WIDTH   = 3'd2;
   localparam logic [2:0] REG_AREA_HEIGHT  = 3'd3;
   localparam logic [2:0] REG_FIXED_WIDTH  = 3'd4;
   localparam logic [2:0] REG_ROW_HEIGHT   = 3'd5;
   localparam logic [2:0] REG_LETTER_LIMIT = 3'd6;
   localparam logic [2:0] REG_MODE_BITS    = 3'd7;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_LIMIT = 2'd2;
   localparam logic [1:0] ST_CLIP  = 2'd3;

   // Mode bit positions
   localparam int MODE_UPPER = 0;
   localparam int MODE_BIG   = 1;
   localparam int MODE_PROP  = 2;
   localparam int MODE_CLIP  = 3;

   localparam logic [6:0] CODE_SPACE   = 7'h20;
   localparam logic [6:0] CODE_LOWER   = 7'h60;
   localparam logic [6:0] CODE_NEWLINE = 7'h0A;

   typedef enum logic [2:0] {
      OP_CHAR,
      OP_RESET,
      OP_OFFSET,
      OP_SAVE,
      OP_RESTORE,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [9:0]  origin_x;
      logic [8:0]  origin_y;
      logic [9:0]  area_width;
      logic [8:0]  area_height;
      logic [7:0]  fixed_width;
      logic [7:0]  row_height;
      logic [10:0] letter_limit;
      logic [3:0]  mode_bits;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic        ctrl;
      logic        newline;
      logic        space;
      logic [7:0]  adv;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  tex_u;
      logic [5:0]  tex_v;
      logic [1:0]  palette;
   } entry_type;

   typedef struct packed {
      logic        sprite_valid;
      logic [15:0] sprite_x;
      logic [15:0] sprite_y;
      logic [7:0]  tex_u;
      logic [5:0]  tex_v;
      logic [1:0]  palette_select;
      logic [1:0]  status;
      logic [15:0] cursor_x;
      logic [15:0] cursor_y;
      logic [10:0] letter_count;
   } result_type;

endpackage

// ----- hdl/tcgl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tcgl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tcgl_front.sv -----
// Front end: accepts requests, decodes and classifies them, owns the glyph width table.
// Depends on tcgl_pkg and tcgl_ram; feeds tcgl_queue.
module tcgl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [2:0]        req_type,
   input  logic [6:0]        char_code,
   input  logic [15:0]       offset_x,
   input  logic [15:0]       offset_y,
   input  logic [6:0]        width_index,
   input  logic [7:0]        width_value,
   input  tcgl_pkg::cfg_type cfg,
   output logic              push,
   output tcgl_pkg::entry_type push_entry,
   input  logic              queue_full
);
   import tcgl_pkg::*;

   logic        accept;
   logic        s1_valid_ff, s1_valid_in;
   entry_type   s1_ff, s1_in;
   logic        s1_prop_ff;
   logic [6:0]  folded;
   logic [6:0]  idx;
   logic [14:0] clamp_x, clamp_y;
   logic        wr_en, rd_en;
   logic [7:0]  table_width;

   assign in_ready = !s1_valid_ff || !queue_full;
   assign accept   = in_valid && in_ready;
   assign push     = s1_valid_ff && !queue_full;

   assign folded  = (cfg.mode_bits[MODE_UPPER] && char_code >= CODE_LOWER) ?
                    char_code - CODE_SPACE : char_code;
   assign idx     = folded - CODE_SPACE;
   assign clamp_x = offset_x[15] ? 15'd0 : offset_x[14:0];
   assign clamp_y = offset_y[15] ? 15'd0 : offset_y[14:0];

   // The table is written and read in request order, so a width write is seen by the
   // very next character.
   assign wr_en = accept && req_type == REQ_WIDTH &&
                  width_index < GLYPH_ADDR_W'(GLYPH_COUNT);
   assign rd_en = accept && req_type == REQ_CHAR && char_code >= CODE_SPACE;

   tcgl_ram #(
      .WIDTH (8),
      .DEPTH (GLYPH_COUNT)
   ) u_width_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (width_index),
      .wr_data (width_value),
      .rd_en   (rd_en),
      .rd_addr (idx),
      .rd_data (table_width)
   );

   always_comb begin
      s1_in         = '0;
      s1_in.ctrl    = char_code < CODE_SPACE;
      s1_in.newline = char_code == CODE_NEWLINE;
      s1_in.space   = idx == 7'd0;
      s1_in.adv     = cfg.fixed_width;
      if (cfg.mode_bits[MODE_BIG]) begin
         s1_in.palette = idx[4:3];
         s1_in.tex_u   = {1'b0, idx[2:0], 4'b0};
         s1_in.tex_v   = {idx[6:5], 4'b0};
      end else begin
         s1_in.palette = idx[5:4];
         s1_in.tex_u   = {1'b0, idx[3:0], 3'b0};
         s1_in.tex_v   = {2'b0, idx[6], 3'b0};
      end
      unique case (req_type)
         REQ_CHAR:    s1_in.op = OP_CHAR;
         REQ_RESET: begin
            s1_in.op    = OP_RESET;
            s1_in.pos_x = {6'b0, cfg.origin_x};
            s1_in.pos_y = {7'b0, cfg.origin_y};
         end
         REQ_OFFSET: begin
            s1_in.op    = OP_OFFSET;
            s1_in.pos_x = {6'b0, cfg.origin_x} + {1'b0, clamp_x};
            s1_in.pos_y = {7'b0, cfg.origin_y} + {1'b0, clamp_y};
         end
         REQ_SAVE:    s1_in.op = OP_SAVE;
         REQ_RESTORE: s1_in.op = OP_RESTORE;
         default:     s1_in.op = OP_NOP;
      endcase
   end

   assign s1_valid_in = accept || (s1_valid_ff && queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_ff      <= s1_in;
         s1_prop_ff <= cfg.mode_bits[MODE_PROP];
      end
   end

   // The table read data is registered together with the decode stage and holds while the stage stalls.
   always_comb begin
      push_entry = s1_ff;
      if (s1_prop_ff) begin
         push_entry.adv = table_width;
      end
   end

endmodule

// ----- hdl/tcgl_queue.sv -----
// Short queue of decoded requests between the front and back ends.
// Depends on tcgl_pkg.
module tcgl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tcgl_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output tcgl_pkg::entry_type head
);
   import tcgl_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hdl/tcgl_back.sv -----
// Back end (depends on tcgl_pkg): holds the cursor, saved positions and letter count,
// executes one decoded request per cycle unless stalled and registers the response.
module tcgl_back #(
   parameter int MAX_LETTERS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcgl_pkg::cfg_type    cfg,
   input  logic                 head_valid,
   input  tcgl_pkg::entry_type  head,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tcgl_pkg::result_type out_result
);
   import tcgl_pkg::*;

   localparam int LimW = ($clog2(MAX_LETTERS + 1) > 11) ? $clog2(MAX_LETTERS + 1) : 11;

   logic [15:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [15:0] line_ff, line_in;
   logic [15:0] saved_x_ff, saved_x_in, saved_y_ff, saved_y_in;
   logic [15:0] saved_line_ff, saved_line_in;
   logic [10:0] count_ff, count_in;
   logic        rsp_valid_ff;
   result_type  res_ff, res_in;

   logic [LimW-1:0] limit;
   logic            at_limit;
   logic [9:0]      y_lim;
   logic [10:0]     x_lim;
   logic [17:0]     y_need, x_need;
   logic            area_full, past_edge;
   logic [15:0]     step_y, place_x, place_y;

   assign limit    = (LimW'(cfg.letter_limit) < LimW'(MAX_LETTERS)) ?
                     LimW'(cfg.letter_limit) : LimW'(MAX_LETTERS);
   assign at_limit = LimW'(count_ff) >= limit;

   // Edge tests use the sign-extended cursor so a negative position never wraps past.
   assign y_lim     = {1'b0, cfg.origin_y} + {1'b0, cfg.area_height};
   assign x_lim     = {1'b0, cfg.origin_x} + {1'b0, cfg.area_width};
   assign y_need    = {{2{cur_y_ff[15]}}, cur_y_ff} + {10'b0, cfg.row_height};
   assign x_need    = {{2{cur_x_ff[15]}}, cur_x_ff} + {10'b0, head.adv};
   assign area_full = $signed(y_need) > $signed({8'b0, y_lim});
   assign past_edge = $signed(x_need) >= $signed({7'b0, x_lim});
   assign step_y    = cur_y_ff + {8'b0, cfg.row_height};
   assign place_x   = past_edge ? line_ff : cur_x_ff;
   assign place_y   = past_edge ? step_y : cur_y_ff;

   assign pop = head_valid && (!rsp_valid_ff || out_ready);

   always_comb begin
      res_in        = '0;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      line_in       = line_ff;
      saved_x_in    = saved_x_ff;
      saved_y_in    = saved_y_ff;
      saved_line_in = saved_line_ff;
      count_in      = count_ff;
      unique case (head.op)
         OP_CHAR: begin
            priority if (area_full) begin
               res_in.status = ST_FULL;
            end else if (at_limit) begin
               res_in.status = ST_LIMIT;
            end else if (head.ctrl) begin
               if (head.newline) begin
                  cur_x_in = line_ff;
                  cur_y_in = step_y;
               end
            end else if (past_edge && cfg.mode_bits[MODE_CLIP]) begin
               res_in.status = ST_CLIP;
            end else begin
               if (!head.space) begin
                  res_in.sprite_valid   = 1'b1;
                  res_in.sprite_x       = place_x;
                  res_in.sprite_y       = place_y;
                  res_in.tex_u          = head.tex_u;
                  res_in.tex_v          = head.tex_v;
                  res_in.palette_select = head.palette;
                  count_in              = count_ff + 11'd1;
               end
               cur_x_in = place_x + {8'b0, head.adv};
               cur_y_in = place_y;
            end
         end
         OP_RESET: begin
            count_in      = '0;
            cur_x_in      = head.pos_x;
            cur_y_in      = head.pos_y;
            line_in       = head.pos_x;
            saved_x_in    = head.pos_x;
            saved_y_in    = head.pos_y;
            saved_line_in = head.pos_x;
         end
         OP_OFFSET: begin
            cur_x_in = head.pos_x;
            cur_y_in = head.pos_y;
            line_in  = head.pos_x;
         end
         OP_SAVE: begin
            saved_x_in    = cur_x_ff;
            saved_y_in    = cur_y_ff;
            saved_line_in = line_ff;
         end
         OP_RESTORE: begin
            cur_x_in = saved_x_ff;
            cur_y_in = saved_y_ff;
            line_in  = saved_line_ff;
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
      res_in.cursor_x     = cur_x_in;
      res_in.cursor_y     = cur_y_in;
      res_in.letter_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         line_ff       <= '0;
         saved_x_ff    <= '0;
         saved_y_ff    <= '0;
         saved_line_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            cur_x_ff      <= cur_x_in;
            cur_y_ff      <= cur_y_in;
            line_ff       <= line_in;
            saved_x_ff    <= saved_x_in;
            saved_y_ff    <= saved_y_in;
            saved_line_ff <= saved_line_in;
            count_ff      <= count_in;
            rsp_valid_ff  <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
      if (pop) begin
         res_ff <= res_in;
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_result = res_ff;

endmodule

// ----- hdl/text_cursor_glyph_layout.sv -----
// Text cursor and glyph layout engine, top level.
// Depends on tcgl_pkg, tcgl_front, tcgl_queue and tcgl_back.
//
// Usage:
//   Requests arrive on the req_ stream (kind on req_tuser, arguments on req_tdata);
//   every request produces exactly one response on the rsp_ stream, in order.
//   Configuration registers are written through csr_valid/csr_index/csr_data, which is
//   always ready; write them only while no request is in flight.
//   Path: an accepted request passes through the decode stage, the queue and the
//   response register before its response is presented with rsp_tvalid high.
//   Throughput: one request per cycle sustained while rsp_tready stays high; the back
//   end's cursor update is the loop that sets this.
//   When the receiver holds rsp_tready low the response register holds its value, the
//   four-entry queue and the decode stage fill, and req_tready then falls; nothing is lost.
//   Reset clears the cursor, saved positions, letter count and queue, and returns the
//   configuration to its defaults. The glyph width table is not cleared and must be
//   written before proportional widths are used.
module text_cursor_glyph_layout #(
   parameter int MAX_LETTERS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // req_type
   input  logic [55:0] req_tdata,   // char_code, offset_x, offset_y, width_index,
                                    // width_value, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // sprite_valid, status
   output logic [95:0] rsp_tdata,   // sprite_x, sprite_y, tex_u, tex_v, palette_select,
                                    // cursor_x, cursor_y, letter_count, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data
);
   import tcgl_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       push, queue_full, pop, head_valid;
   entry_type  push_entry, head;
   result_type result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ORIGIN_X:     cfg_in.origin_x     = csr_data[9:0];
            REG_ORIGIN_Y:     cfg_in.origin_y     = csr_data[8:0];
            REG_AREA_WIDTH:   cfg_in.area_width   = csr_data[9:0];
            REG_AREA_HEIGHT:  cfg_in.area_height  = csr_data[8:0];
            REG_FIXED_WIDTH:  cfg_in.fixed_width  = csr_data[7:0];
            REG_ROW_HEIGHT:   cfg_in.row_height   = csr_data[7:0];
            REG_LETTER_LIMIT: cfg_in.letter_limit = csr_data;
            REG_MODE_BITS:    cfg_in.mode_bits    = csr_data[3:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{origin_x: 10'd0, origin_y: 9'd0, area_width: 10'd0,
                     area_height: 9'd0, fixed_width: 8'd8, row_height: 8'd8,
                     letter_limit: 11'd1024, mode_bits: 4'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcgl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .req_type    (req_tuser),
      .char_code   (req_tdata[6:0]),
      .offset_x    (req_tdata[22:7]),
      .offset_y    (req_tdata[38:23]),
      .width_index (req_tdata[45:39]),
      .width_value (req_tdata[53:46]),
      .cfg         (cfg_ff),
      .push        (push),
      .push_entry  (push_entry),
      .queue_full  (queue_full)
   );

   tcgl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   tcgl_back #(
      .MAX_LETTERS (MAX_LETTERS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tuser = {result.status, result.sprite_valid};
   assign rsp_tdata = {5'b0, result.letter_count, result.cursor_y, result.cursor_x,
                       result.palette_select, result.tex_v, result.tex_u,
                       result.sprite_y, result.sprite_x};

   // A sprite is only ever emitted for a request that was taken.
   a_sprite_status : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] == ST_OK)
      else $error("sprite emitted with a failure status");

   // Without a sprite the sprite position and texture fields read as zero.
   a_sprite_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[47:0] == 48'd0)
      else $error("sprite fields not cleared for a request without a sprite");

   // Nothing is queued across reset, so no response follows it straight away.
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response presented right after reset");

endmodule

// ----- tb/tb_text_cursor_glyph_layout.sv -----
// Self-checking testbench for the text cursor glyph layout block.
// Drives layout requests and configuration writes and checks every response against
// an in-bench model of the cursor. Depends on tcgl_pkg and text_cursor_glyph_layout.
`timescale 1ns / 100ps

module tb_text_cursor_glyph_layout;
   import tcgl_pkg::*;

   localparam int LETTER_CAP     = 1024;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;

   // Idling schemes, rotated from one phase to the next
   localparam int IDLE_NONE     = 0;
   localparam int IDLE_SENDER   = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH     = 3;

   typedef struct {
      logic [2:0]  kind;
      logic [6:0]  code;
      logic [15:0] off_x;
      logic [15:0] off_y;
      logic [6:0]  widx;
      logic [7:0]  wval;
   } text_request_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser   = '0;
   logic [55:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [2:0]  rsp_tuser;
   logic [95:0] rsp_tdata;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index   = '0;
   logic [10:0] csr_data    = '0;

   text_request_type text_requests[$];
   result_type       expected_layouts[$];
   int               failures        = 0;
   int               idle_scheme     = IDLE_NONE;
   int               quiet_cycles    = 0;

   // Shadow of the block's cursor state and configuration
   cfg_type     cfg_shadow;
   logic [15:0] pen_x, pen_y, line_x;
   logic [15:0] mark_x, mark_y, mark_line;
   logic [10:0] glyph_total;
   logic [7:0]  advance_table [GLYPH_COUNT];

   text_cursor_glyph_layout #(.MAX_LETTERS(LETTER_CAP)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic result_type predict_layout(input text_request_type rq);
      result_type  res;
      int          limit;
      logic [6:0]  folded;
      logic [6:0]  glyph;
      logic [7:0]  adv;
      logic        at_right;
      res = '0;
      limit = (cfg_shadow.letter_limit < LETTER_CAP) ? int'(cfg_shadow.letter_limit)
                                                     : LETTER_CAP;
      case (rq.kind)
         REQ_CHAR: begin
            if (int'($signed(pen_y)) + int'(cfg_shadow.row_height) >
                int'(cfg_shadow.origin_y) + int'(cfg_shadow.area_height)) begin
               res.status = ST_FULL;
            end else if (int'(glyph_total) >= limit) begin
               res.status = ST_LIMIT;
            end else if (rq.code < CODE_SPACE) begin
               if (rq.code == CODE_NEWLINE) begin
                  pen_x = line_x;
                  pen_y = pen_y + 16'(cfg_shadow.row_height);
               end
            end else begin
               folded = (cfg_shadow.mode_bits[MODE_UPPER] && rq.code >= CODE_LOWER) ?
                        rq.code - CODE_SPACE : rq.code;
               glyph = folded - CODE_SPACE;
               adv = cfg_shadow.mode_bits[MODE_PROP] ? advance_table[glyph]
                                                     : cfg_shadow.fixed_width;
               at_right = int'($signed(pen_x)) + int'(adv) >=
                          int'(cfg_shadow.origin_x) + int'(cfg_shadow.area_width);
               if (at_right && cfg_shadow.mode_bits[MODE_CLIP]) begin
                  res.status = ST_CLIP;
               end else begin
                  // A wrap does not repeat the area-full check.
                  if (at_right) begin
                     pen_x = line_x;
                     pen_y = pen_y + 16'(cfg_shadow.row_height);
                  end
                  if (glyph != '0) begin
                     res.sprite_valid = 1'b1;
                     res.sprite_x = pen_x;
                     res.sprite_y = pen_y;
                     if (cfg_shadow.mode_bits[MODE_BIG]) begin
                        res.palette_select = glyph[4:3];
                        res.tex_u = {1'b0, glyph[2:0], 4'b0000};
                        res.tex_v = {glyph[6:5], 4'b0000};
                     end else begin
                        res.palette_select = glyph[5:4];
                        res.tex_u = {1'b0, glyph[3:0], 3'b000};
                        res.tex_v = {2'b00, glyph[6], 3'b000};
                     end
                     glyph_total = glyph_total + 11'd1;
                  end
                  pen_x = pen_x + 16'(adv);
               end
            end
         end
         REQ_RESET: begin
            glyph_total = '0;
            pen_x = 16'(cfg_shadow.origin_x);
            pen_y = 16'(cfg_shadow.origin_y);
            line_x = pen_x;
            mark_x = pen_x;
            mark_y = pen_y;
            mark_line = pen_x;
         end
         REQ_OFFSET: begin
            pen_x = 16'(cfg_shadow.origin_x) + (rq.off_x[15] ? 16'd0 : rq.off_x);
            pen_y = 16'(cfg_shadow.origin_y) + (rq.off_y[15] ? 16'd0 : rq.off_y);
            line_x = pen_x;
         end
         REQ_SAVE: begin
            mark_x = pen_x;
            mark_y = pen_y;
            mark_line = line_x;
         end
         REQ_RESTORE: begin
            pen_x = mark_x;
            pen_y = mark_y;
            line_x = mark_line;
         end
         REQ_WIDTH: begin
            if (rq.widx < GLYPH_COUNT) advance_table[rq.widx] = rq.wval;
         end
         default: ;
      endcase
      res.cursor_x = pen_x;
      res.cursor_y = pen_y;
      res.letter_count = glyph_total;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         failures++;
      end
   endtask

   // Request driver
   always @(posedge clock) begin
      text_request_type rq;
      int               gap_pct;
      gap_pct = (idle_scheme == IDLE_SENDER) ? 73 : (idle_scheme == IDLE_BOTH) ? 13 : 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (text_requests.size() > 0 && $urandom_range(99) >= gap_pct) begin
            rq = text_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= rq.kind;
            req_tdata <= {2'b00, rq.wval, rq.widx, rq.off_y, rq.off_x, rq.code};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(posedge clock) begin
      int stall_pct;
      stall_pct = (idle_scheme == IDLE_RECEIVER) ? 73 : (idle_scheme == IDLE_BOTH) ? 13 : 0;
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Monitor: predicts on each accepted request, checks each accepted response
   always @(posedge clock) begin
      text_request_type rq;
      result_type       want;
      if (reset) begin
         cfg_shadow = '0;
         cfg_shadow.fixed_width = 8'd8;
         cfg_shadow.row_height = 8'd8;
         cfg_shadow.letter_limit = 11'd1024;
         pen_x = '0; pen_y = '0; line_x = '0;
         mark_x = '0; mark_y = '0; mark_line = '0;
         glyph_total = '0;
         expected_layouts.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            rq.kind = req_tuser;
            rq.code = req_tdata[6:0];
            rq.off_x = req_tdata[22:7];
            rq.off_y = req_tdata[38:23];
            rq.widx = req_tdata[45:39];
            rq.wval = req_tdata[53:46];
            expected_layouts.push_back(predict_layout(rq));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_layouts.size() == 0) begin
               $error("response arrived with no request outstanding");
               failures++;
            end else begin
               want = expected_layouts.pop_front();
               check_field("sprite_valid", 16'(want.sprite_valid), 16'(rsp_tuser[0]));
               check_field("status", 16'(want.status), 16'(rsp_tuser[2:1]));
               check_field("sprite_x", want.sprite_x, rsp_tdata[15:0]);
               check_field("sprite_y", want.sprite_y, rsp_tdata[31:16]);
               check_field("tex_u", 16'(want.tex_u), 16'(rsp_tdata[39:32]));
               check_field("tex_v", 16'(want.tex_v), 16'(rsp_tdata[45:40]));
               check_field("palette_select", 16'(want.palette_select),
                           16'(rsp_tdata[47:46]));
               check_field("cursor_x", want.cursor_x, rsp_tdata[63:48]);
               check_field("cursor_y", want.cursor_y, rsp_tdata[79:64]);
               check_field("letter_count", 16'(want.letter_count), 16'(rsp_tdata[90:80]));
            end
         end
      end
   end

   // Watchdog on cycles in which no handshake completes
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ORIGIN_X:     cfg_shadow.origin_x = val[9:0];
         REG_ORIGIN_Y:     cfg_shadow.origin_y = val[8:0];
         REG_AREA_WIDTH:   cfg_shadow.area_width = val[9:0];
         REG_AREA_HEIGHT:  cfg_shadow.area_height = val[8:0];
         REG_FIXED_WIDTH:  cfg_shadow.fixed_width = val[7:0];
         REG_ROW_HEIGHT:   cfg_shadow.row_height = val[7:0];
         REG_LETTER_LIMIT: cfg_shadow.letter_limit = val;
         REG_MODE_BITS:    cfg_shadow.mode_bits = val[3:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_layout(input int ox, input int oy, input int w, input int h,
                             input int fw, input int rh, input int lim, input int mode);
      write_reg(REG_ORIGIN_X, 11'(ox));
      write_reg(REG_ORIGIN_Y, 11'(oy));
      write_reg(REG_AREA_WIDTH, 11'(w));
      write_reg(REG_AREA_HEIGHT, 11'(h));
      write_reg(REG_FIXED_WIDTH, 11'(fw));
      write_reg(REG_ROW_HEIGHT, 11'(rh));
      write_reg(REG_LETTER_LIMIT, 11'(lim));
      write_reg(REG_MODE_BITS, 11'(mode));
   endtask

   task automatic push_request(input logic [2:0] kind, input logic [6:0] code,
                               input logic [15:0] ox, input logic [15:0] oy,
                               input logic [6:0] widx, input logic [7:0] wval);
      text_request_type rq;
      rq.kind = kind; rq.code = code; rq.off_x = ox; rq.off_y = oy;
      rq.widx = widx; rq.wval = wval;
      text_requests.push_back(rq);
   endtask

   task automatic push_char(input logic [6:0] code);
      push_request(REQ_CHAR, code, '0, '0, '0, '0);
   endtask

   task automatic push_offset(input logic [15:0] ox, input logic [15:0] oy);
      push_request(REQ_OFFSET, '0, ox, oy, '0, '0);
   endtask

   task automatic queue_random_text(input int count);
      logic [2:0]  kind;
      logic [6:0]  code;
      logic [15:0] ox, oy;
      logic [6:0]  widx;
      logic [7:0]  wval;
      int          pick;
      repeat (count) begin
         pick = $urandom_range(99);
         kind = (pick < 62) ? REQ_CHAR : (pick < 70) ? REQ_RESET : (pick < 77) ? REQ_OFFSET :
                (pick < 82) ? REQ_SAVE : (pick < 87) ? REQ_RESTORE : (pick < 96) ? REQ_WIDTH :
                3'($urandom_range(6, 7));
         pick = $urandom_range(99);
         code = (pick < 8)  ? CODE_NEWLINE :
                (pick < 12) ? 7'($urandom_range(0, 31)) :
                (pick < 20) ? CODE_SPACE :
                (pick < 35) ? 7'($urandom_range(96, 127)) : 7'($urandom_range(33, 127));
         ox = ($urandom_range(99) < 75) ? 16'($urandom_range(0, 400)) : 16'($urandom());
         oy = ($urandom_range(99) < 75) ? 16'($urandom_range(0, 300)) : 16'($urandom());
         widx = ($urandom_range(99) < 90) ? 7'($urandom_range(0, 95))
                                          : 7'($urandom_range(96, 127));
         wval = ($urandom_range(99) < 70) ? 8'($urandom_range(1, 20)) : 8'($urandom());
         push_request(kind, code, ox, oy, widx, wval);
      end
   endtask

   task automatic drain_layout;
      do @(posedge clock);
      while (text_requests.size() != 0 || req_tvalid || expected_layouts.size() != 0);
      // Allow the response pipeline to settle before the next register write.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 8; phase++) begin
         idle_scheme = phase % 4;
         case (phase)
            0: set_layout(16, 8, 200, 120, 8, 8, 1024, 0);
            1: set_layout(1023, 511, 1023, 511, 255, 255, 1024, 15);
            2: set_layout(100, 50, 300, 200, 12, 16, 7, 5);
            3: set_layout(0, 0, 0, 0, 0, 0, 0, 2);
            4: set_layout(512, 256, 640, 240, 8, 8, 20, 11);
            5: set_layout(40, 20, 500, 400, 10, 12, 1024, 6);
            6: set_layout(0, 0, 1023, 511, 16, 8, 3, 13);
            default: set_layout(200, 100, 800, 300, 6, 10, 1024, 1);
         endcase
         if (phase == 0) begin
            // Every width entry is written before proportional mode can read it.
            for (int g = 0; g < GLYPH_COUNT; g++)
               push_request(REQ_WIDTH, '0, '0, '0, 7'(g), 8'($urandom_range(1, 16)));
            push_request(REQ_RESET, '0, '0, '0, '0, '0);
            push_char(7'("A"));
            push_char(7'h7F);
            push_char(CODE_SPACE);
            push_char(CODE_NEWLINE);
            push_char(7'h00);
            push_char(7'h1F);
            push_char(7'("a"));
            push_request(REQ_WIDTH, '0, '0, '0, 7'd0, 8'd0);
            push_request(REQ_WIDTH, '0, '0, '0, 7'd95, 8'd255);
            push_request(REQ_WIDTH, '0, '0, '0, 7'd96, 8'd3);
            push_request(REQ_WIDTH, '0, '0, '0, 7'd127, 8'd255);
            push_offset(16'h8000, 16'hFFFF);
            push_offset(16'h7FFF, 16'h7FFF);
            push_char(7'("M"));
            push_offset(16'd0, 16'd0);
            push_request(REQ_SAVE, '0, '0, '0, '0, '0);
            push_offset(16'd50, 16'd30);
            push_request(REQ_RESTORE, '0, '0, '0, '0, '0);
            push_request(3'd6, 7'("Z"), '1, '1, '1, '1);
            push_request(3'd7, 7'("Z"), '1, '1, '1, '1);
            // Close to the right edge so that the third glyph wraps.
            push_offset(16'd180, 16'd0);
            repeat (4) push_char(7'("W"));
            // Low enough that the next row no longer fits.
            push_offset(16'd0, 16'd115);
            push_char(7'("B"));
            push_request(REQ_RESET, '0, '0, '0, '0, '0);
         end
         queue_random_text(250);
         drain_layout();
      end
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/tcgl_pkg.sv
hdl/tcgl_ram.sv
hdl/tcgl_front.sv
hdl/tcgl_queue.sv
hdl/tcgl_back.sv
hdl/text_cursor_glyph_layout.sv
tb/tb_text_cursor_glyph_layout.sv
